@@ design/cbt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbt_pkg: shared definitions for the CAN bit timing calculator
// Widths, limits, microcode word layout, status bundle and the segment split
// table used by the sequencer and the datapath.
// ----------------------------------------------------------------------------
package cbt_pkg;

	localparam int CLK_W   = 32;
	localparam int RATE_W  = 20;
	localparam int SUM_W   = 5;
	localparam int CNT_W   = 5;
	localparam int STEP_W  = 4;
	localparam int PRE_W   = 10;
	localparam int SEG1_W  = 4;
	localparam int SEG2_W  = 3;
	localparam int SP_W    = 10;

	localparam logic [CLK_W-1:0]  CLOCK_RESET = CLK_W'(100000);
	localparam logic [RATE_W-1:0] FAST_RATE   = RATE_W'(1000000);
	localparam logic [SUM_W-1:0]  FAST_SUM    = SUM_W'(10 - 1);
	localparam logic [SUM_W-1:0]  SLOW_SUM    = SUM_W'(17 - 1);
	localparam logic [SUM_W-1:0]  MIN_SUM     = SUM_W'(2);
	localparam logic [CNT_W-1:0]  DIV_LAST    = CNT_W'(CLK_W - 1);

	localparam int MAX_SEG1      = 16;
	localparam int MAX_SEG2      = 8;
	localparam int MAX_PRESCALER = 1024;

	// One remainder lane per candidate quanta count, 3 .. 17.
	localparam int NUM_LANES = 15;
	localparam int LANE_W    = 4;
	localparam int MOD_W     = 5;

	typedef logic [STEP_W-1:0] step_t;

	// Program addresses.
	localparam step_t ST_WAIT   = STEP_W'(0);
	localparam step_t ST_DIV_A  = STEP_W'(1);
	localparam step_t ST_SAVE   = STEP_W'(2);
	localparam step_t ST_TEST   = STEP_W'(3);
	localparam step_t ST_LOW    = STEP_W'(4);
	localparam step_t ST_DEC    = STEP_W'(5);
	localparam step_t ST_LOAD_B = STEP_W'(6);
	localparam step_t ST_DIV_B  = STEP_W'(7);
	localparam step_t ST_RESULT = STEP_W'(8);
	localparam step_t ST_DONE   = STEP_W'(9);

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_DIV_A,
		OP_SAVE,
		OP_DEC_SUM,
		OP_LOAD_B,
		OP_DIV_B,
		OP_RESULT
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_IN,
		C_CNT_NZ,
		C_MOD_ZERO,
		C_SUM_LOW,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_t;

	typedef struct packed {
		logic cnt_nz;
		logic mod_zero;
		logic sum_low;
		logic out_busy;
	} stat_t;

	typedef struct packed {
		logic [4:0]      seg1;
		logic [3:0]      seg2;
		logic [SP_W-1:0] sp;
	} seg_t;

	// Segment split for a segment sum of 2 .. 16: rounded 7/8 split, or the
	// truncated one where the rounded split samples later than 900 permill.
	function automatic seg_t seg_entry(input logic [SUM_W-1:0] s);
		seg_t e;
		e = '0;
		unique case (s)
			5'd2:    e = '{seg1: 5'd1,  seg2: 4'd1, sp: 10'd666};
			5'd3:    e = '{seg1: 5'd2,  seg2: 4'd1, sp: 10'd750};
			5'd4:    e = '{seg1: 5'd3,  seg2: 4'd1, sp: 10'd800};
			5'd5:    e = '{seg1: 5'd4,  seg2: 4'd1, sp: 10'd833};
			5'd6:    e = '{seg1: 5'd5,  seg2: 4'd1, sp: 10'd857};
			5'd7:    e = '{seg1: 5'd6,  seg2: 4'd1, sp: 10'd875};
			5'd8:    e = '{seg1: 5'd7,  seg2: 4'd1, sp: 10'd888};
			5'd9:    e = '{seg1: 5'd8,  seg2: 4'd1, sp: 10'd900};
			5'd10:   e = '{seg1: 5'd8,  seg2: 4'd2, sp: 10'd818};
			5'd11:   e = '{seg1: 5'd9,  seg2: 4'd2, sp: 10'd833};
			5'd12:   e = '{seg1: 5'd10, seg2: 4'd2, sp: 10'd846};
			5'd13:   e = '{seg1: 5'd11, seg2: 4'd2, sp: 10'd857};
			5'd14:   e = '{seg1: 5'd12, seg2: 4'd2, sp: 10'd866};
			5'd15:   e = '{seg1: 5'd13, seg2: 4'd2, sp: 10'd875};
			5'd16:   e = '{seg1: 5'd14, seg2: 4'd2, sp: 10'd882};
			default: e = '0;
		endcase
		return e;
	endfunction

endpackage
`default_nettype wire

@@ design/cbt_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbt_seq: microcode sequencer
// Step counter and program ROM; one control word per step, with a
// conditional jump evaluated on datapath status or on in_valid.
// ----------------------------------------------------------------------------
module cbt_seq
	import cbt_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire stat_t stat,
	output ctrl_t      ctrl,
	output logic       in_ready
);

	step_t step_q;
	step_t step_d;
	logic  take;

	function automatic ctrl_t ucode(input step_t s);
		ctrl_t w;
		w = '{op: OP_NOP, cond: C_ALWAYS, target: ST_WAIT};
		unique case (s)
			ST_WAIT:   w = '{op: OP_LOAD,    cond: C_NO_IN,    target: ST_WAIT};
			ST_DIV_A:  w = '{op: OP_DIV_A,   cond: C_CNT_NZ,   target: ST_DIV_A};
			ST_SAVE:   w = '{op: OP_SAVE,    cond: C_NEVER,    target: ST_WAIT};
			ST_TEST:   w = '{op: OP_NOP,     cond: C_MOD_ZERO, target: ST_LOAD_B};
			ST_LOW:    w = '{op: OP_NOP,     cond: C_SUM_LOW,  target: ST_RESULT};
			ST_DEC:    w = '{op: OP_DEC_SUM, cond: C_ALWAYS,   target: ST_TEST};
			ST_LOAD_B: w = '{op: OP_LOAD_B,  cond: C_NEVER,    target: ST_WAIT};
			ST_DIV_B:  w = '{op: OP_DIV_B,   cond: C_CNT_NZ,   target: ST_DIV_B};
			ST_RESULT: w = '{op: OP_RESULT,  cond: C_OUT_BUSY, target: ST_RESULT};
			ST_DONE:   w = '{op: OP_NOP,     cond: C_ALWAYS,   target: ST_WAIT};
			default:   w = '{op: OP_NOP,     cond: C_ALWAYS,   target: ST_WAIT};
		endcase
		return w;
	endfunction

	assign ctrl     = ucode(step_q);
	assign in_ready = (ctrl.op == OP_LOAD);

	always_comb begin
		unique case (ctrl.cond)
			C_NEVER:    take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_NO_IN:    take = ~in_valid;
			C_CNT_NZ:   take = stat.cnt_nz;
			C_MOD_ZERO: take = stat.mod_zero;
			C_SUM_LOW:  take = stat.sum_low;
			C_OUT_BUSY: take = stat.out_busy;
			default:    take = 1'b1;
		endcase
		step_d = take ? ctrl.target : step_q + STEP_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_WAIT;
		end else begin
			step_q <= step_d;
		end
	end

endmodule
`default_nettype wire

@@ design/cbt_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbt_dpath: bit timing datapath
// Clock register, shared restoring divider, remainder lanes for the quanta
// candidates, segment sum counter and the result register.
// ----------------------------------------------------------------------------
module cbt_dpath
	import cbt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ctrl_t             ctrl,
	output stat_t                  stat,
	input  wire logic              cfg_wr_en,
	input  wire logic [CLK_W-1:0]  cfg_wr_data,
	input  wire logic              in_valid,
	input  wire logic [RATE_W-1:0] bitrate,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   ok,
	output logic [PRE_W-1:0]       prescaler_code,
	output logic [SEG1_W-1:0]      seg1_code,
	output logic [SEG2_W-1:0]      seg2_code,
	output logic [SP_W-1:0]        sample_point
);

	logic [CLK_W-1:0]  clock_q;
	logic [RATE_W-1:0] rate_q;
	logic [RATE_W-1:0] rem_q;
	logic [CLK_W-1:0]  quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  sum_q;
	logic              exact_q;
	logic              found_q;
	logic [MOD_W-1:0]  mod_q [NUM_LANES];

	logic                   out_valid_q;
	logic                   ok_q;
	logic [PRE_W-1:0]       presc_q;
	logic [SEG1_W-1:0]      seg1_q;
	logic [SEG2_W-1:0]      seg2_q;
	logic [SP_W-1:0]        sp_q;

	logic [RATE_W-1:0] divisor;
	logic [RATE_W:0]   trial;
	logic [RATE_W:0]   diff;
	logic              qbit;
	logic [RATE_W-1:0] rem_next;
	logic [SUM_W-1:0]  lane_off;
	logic [LANE_W-1:0] lane_idx;
	logic              div_op;
	logic              out_busy;
	seg_t              seg;
	logic              presc_ok;
	logic              seg_ok;
	logic              good;

	// One restoring step: quotient bits leave MSB first.
	always_comb begin
		divisor  = (ctrl.op == OP_DIV_B) ? RATE_W'(sum_q + SUM_W'(1)) : rate_q;
		trial    = {rem_q, quo_q[CLK_W-1]};
		diff     = trial - {1'b0, divisor};
		qbit     = (trial >= {1'b0, divisor});
		rem_next = qbit ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
		div_op   = (ctrl.op == OP_DIV_A) || (ctrl.op == OP_DIV_B);
	end

	assign lane_off = sum_q - MIN_SUM;
	assign lane_idx = lane_off[LANE_W-1:0];
	assign out_busy = out_valid_q & ~out_ready;

	assign stat = '{cnt_nz:   (cnt_q != '0),
	                mod_zero: (mod_q[lane_idx] == '0),
	                sum_low:  (sum_q <= MIN_SUM),
	                out_busy: out_busy};

	// Result check: the quotient register holds the prescaler after pass B.
	always_comb begin
		seg      = seg_entry(sum_q);
		presc_ok = (quo_q != '0) && (quo_q <= CLK_W'(MAX_PRESCALER));
		seg_ok   = (seg.seg1 >= 5'd1) && (seg.seg1 <= 5'(MAX_SEG1)) &&
		           (seg.seg2 >= 4'd1) && (seg.seg2 <= 4'(MAX_SEG2));
		good     = found_q && exact_q && presc_ok && seg_ok && (rate_q != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= CLOCK_RESET;
		end else if (cfg_wr_en) begin
			clock_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if ((ctrl.op == OP_LOAD && in_valid) || ctrl.op == OP_LOAD_B) begin
			cnt_q <= DIV_LAST;
		end else if (div_op) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_LOAD: begin
				if (in_valid) begin
					rate_q  <= bitrate;
					quo_q   <= clock_q;
					rem_q   <= '0;
					found_q <= 1'b0;
					sum_q   <= (bitrate >= FAST_RATE) ? FAST_SUM : SLOW_SUM;
				end
			end
			OP_DIV_A, OP_DIV_B: begin
				rem_q <= rem_next;
				quo_q <= {quo_q[CLK_W-2:0], qbit};
			end
			OP_SAVE: begin
				// The quotient rebuilds the rate exactly when the remainder
				// stays below it.
				exact_q <= ({{(CLK_W-RATE_W){1'b0}}, rem_q} < quo_q);
			end
			OP_DEC_SUM: begin
				sum_q <= sum_q - SUM_W'(1);
			end
			OP_LOAD_B: begin
				rem_q   <= '0;
				found_q <= 1'b1;
			end
			OP_NOP, OP_RESULT: begin
			end
			default: begin
			end
		endcase
	end

	// Remainder lanes follow the quotient bits of the first division, so each
	// lane ends holding the quotient modulo its quanta candidate.
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_LANES; i++) begin
			if (ctrl.op == OP_LOAD && in_valid) begin
				mod_q[i] <= '0;
			end else if (ctrl.op == OP_DIV_A) begin
				if ({mod_q[i], qbit} >= 6'(i + 3)) begin
					mod_q[i] <= 5'({mod_q[i], qbit} - 6'(i + 3));
				end else begin
					mod_q[i] <= 5'({mod_q[i], qbit});
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.op == OP_RESULT && !out_busy) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_RESULT && !out_busy) begin
			ok_q    <= good;
			presc_q <= good ? quo_q[PRE_W-1:0] - PRE_W'(1) : '0;
			seg1_q  <= good ? SEG1_W'(seg.seg1 - 5'd1) : '0;
			seg2_q  <= good ? SEG2_W'(seg.seg2 - 4'd1) : '0;
			sp_q    <= good ? seg.sp : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign ok             = ok_q;
	assign prescaler_code = presc_q;
	assign seg1_code      = seg1_q;
	assign seg2_code      = seg2_q;
	assign sample_point   = sp_q;

endmodule
`default_nettype wire

@@ design/can_bit_timing_calc_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// can_bit_timing_calc_top: CAN bit timing calculator
// Derives prescaler and segment codes for a wanted bitrate from the
// configured peripheral clock.
// ----------------------------------------------------------------------------
// Each beat on the input carries a wanted bitrate; one result beat follows
// it. The block divides the peripheral clock (clock_hz, written through
// cfg_wr_en/cfg_wr_data, reset value 100000 Hz) by the bitrate, picks the
// largest quanta count per bit (at most 10 at or above 1 Mbps, at most 17
// below, at least 3) that divides that quotient exactly, and splits the
// segments for a sample point near 87.5 percent. The result gives register
// codes (value minus one) and the sample point in permill; when no exact,
// legal timing exists, ok is low and all other fields are zero. The work is
// done by the shared restoring divider, which retires one quotient bit per
// cycle and runs twice (clock over bitrate, then quotient over quanta
// count), and by the microcoded search, which spends three steps on each
// rejected quanta count; at most 14 counts are rejected before a match.
// Items are taken one at a time. The result sits in an output register, so
// a new input beat is taken once the sequencer has gone on from its result
// step through its done step to its wait step, even while the result still
// waits to be taken; a finished result that finds the output register still
// occupied waits until it is free. Write clock_hz only while the block is
// idle.
// ----------------------------------------------------------------------------
module can_bit_timing_calc_top
	import cbt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [CLK_W-1:0]  cfg_wr_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [RATE_W-1:0] bitrate,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   ok,
	output logic [PRE_W-1:0]       prescaler_code,
	output logic [SEG1_W-1:0]      seg1_code,
	output logic [SEG2_W-1:0]      seg2_code,
	output logic [SP_W-1:0]        sample_point
);

	ctrl_t ctrl;
	stat_t stat;

	// The sequencer steps through the program and raises in_ready only on its
	// wait step.
	cbt_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.ctrl     (ctrl),
		.in_ready (in_ready)
	);

	// The datapath holds the clock register, the divider, the remainder lanes
	// and the result register.
	cbt_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.stat           (stat),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.bitrate        (bitrate),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.ok             (ok),
		.prescaler_code (prescaler_code),
		.seg1_code      (seg1_code),
		.seg2_code      (seg2_code),
		.sample_point   (sample_point)
	);

	// Once an input beat is taken, the block is busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken again right after an accepted beat");

	// A failed result carries all-zero fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !ok) |-> (prescaler_code == '0 && seg1_code == '0 &&
		                        seg2_code == '0 && sample_point == '0))
		else $error("failed result with nonzero fields");

	// A good result samples between 666 and 900 permill, with a short BS2.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ok) |-> (sample_point >= SP_W'(666) &&
		                       sample_point <= SP_W'(900) &&
		                       seg2_code <= SEG2_W'(1)))
		else $error("good result with sample point or BS2 out of range");

endmodule
`default_nettype wire
